>>> rtl/ggm_pkg.sv
// ----------------------------------------------------------------------------
// ggm_pkg
// Shared types and constants of the granular grain mixer.
// ----------------------------------------------------------------------------
package ggm_pkg;

  localparam int unsigned GrainSlots  = 16;
  localparam int unsigned WindowDepth = 1024;
  localparam int unsigned SourceDepth = 65536;

  typedef enum logic [1:0] {
    KIND_SRC  = 2'd0,
    KIND_WIN  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_GRAIN_LEN = 3'd0,
    CFG_SPAWN_INT = 3'd1,
    CFG_PITCH     = 3'd2,
    CFG_SCAN      = 3'd3,
    CFG_SRC_LEN   = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_READ,
    ST_ADDR,
    ST_WAIT,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

endpackage

>>> rtl/granular_grain_mixer_core.sv
// ----------------------------------------------------------------------------
// granular_grain_mixer_core
// Grain engine: source and window memories, grain slot memory, mixing sequencer.
// ----------------------------------------------------------------------------
// A load item is written into its memory when it is accepted. A tick keeps the
// input stalled through a spawn step, a sequence of steps for each grain slot
// and a step that loads the output register. The result is offered as that
// last step ends, and the next item can be taken once the sequencer is idle
// again. For each slot the sequencer reads the slot record from the grain
// memory, forms the read position, reads the two neighboring source samples
// one after the other while the window entry is weighted by the grain gain,
// interpolates, and finally multiplies and accumulates while the slot record
// is written back aged. The single source read port and one multiplier per
// step set this sequence. A result that waits under stall holds the input
// stalled as well: the next item is taken as soon as the previous result has
// been handed over or is being handed over.
module granular_grain_mixer_core #(
  parameter int unsigned GRAIN_SLOTS  = ggm_pkg::GrainSlots,
  parameter int unsigned WINDOW_DEPTH = ggm_pkg::WindowDepth,
  parameter int unsigned SOURCE_DEPTH = ggm_pkg::SourceDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] load_value_i,
  input  logic signed [16:0] position_jitter_i,
  input  logic signed [15:0] gain_offset_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] mixed_sample_o,
  output logic [4:0]         active_grains_o,
  output logic               spawned_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i
);

  localparam int unsigned SW = (GRAIN_SLOTS > 1) ? $clog2(GRAIN_SLOTS) : 1;
  localparam int unsigned CW = $clog2(GRAIN_SLOTS + 1);
  localparam int unsigned WW = $clog2(WINDOW_DEPTH);
  localparam int unsigned AW = $clog2(SOURCE_DEPTH);

  // Configuration registers.
  logic [15:0] grain_len_q, spawn_int_q, pitch_q, scan_q;
  logic [16:0] src_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grain_len_q <= 16'd2400;
      spawn_int_q <= 16'd4800;
      pitch_q     <= 16'd4096;
      scan_q      <= 16'd32768;
      src_len_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (ggm_pkg::cfg_e'(cfg_index_i))
        ggm_pkg::CFG_GRAIN_LEN: grain_len_q <= cfg_data_i[15:0];
        ggm_pkg::CFG_SPAWN_INT: spawn_int_q <= cfg_data_i[15:0];
        ggm_pkg::CFG_PITCH:     pitch_q     <= cfg_data_i[15:0];
        ggm_pkg::CFG_SCAN:      scan_q      <= cfg_data_i[15:0];
        ggm_pkg::CFG_SRC_LEN:   src_len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memories.
  logic signed [15:0] src_mem [SOURCE_DEPTH];
  logic signed [15:0] win_mem [WINDOW_DEPTH];
  // Grain record: active, start, age, gain.
  logic [48:0]        grain_mem [GRAIN_SLOTS];
  logic [GRAIN_SLOTS-1:0] slot_init_q; // slot written since reset

  ggm_pkg::state_e state_q, state_d;
  logic [SW-1:0] slot_q;
  logic [15:0]   cnt_q;
  logic [SW-1:0] next_q;
  logic [CW-1:0] act_q;
  logic          spawned_q;
  logic signed [51:0] sum_q;

  // Latched tick inputs.
  logic signed [16:0] jit_q;
  logic signed [15:0] goff_q;

  // Slot record after read.
  logic [48:0] rec_rd_q;
  logic        rec_ok;
  logic        g_act;
  logic [15:0] g_start, g_age, g_gain;
  assign rec_ok  = slot_init_q[slot_q];
  assign g_act   = rec_ok & rec_rd_q[48];
  assign g_start = rec_rd_q[47:32];
  assign g_age   = rec_rd_q[31:16];
  assign g_gain  = rec_rd_q[15:0];

  // Source read stage.
  logic [32:0] pos_q;
  logic        play_q;
  logic signed [15:0] s1_q;
  logic        phase_q; // 0 reading idx, 1 reading idx+1
  logic signed [16:0] lerp_q;
  logic signed [32:0] wg_q;

  logic accept;
  assign in_stall_o = (state_q != ggm_pkg::ST_IDLE) || (out_valid_o && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Spawn decision.
  logic [15:0] cnt_inc;
  logic        do_spawn;
  assign cnt_inc  = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
  assign do_spawn = (cnt_inc >= spawn_int_q) && (src_len_q != '0) &&
                    ({1'b0, act_q} < (CW+1)'(GRAIN_SLOTS));

  logic signed [18:0] pos_s, hi_s, st_s;
  logic signed [17:0] gain_s;
  always_comb begin
    pos_s = 19'(signed'({1'b0, scan_q})) + 19'(jit_q);
    hi_s  = signed'({2'b00, src_len_q}) - signed'({3'b000, grain_len_q});
    st_s  = (pos_s > hi_s) ? hi_s : pos_s;
    if (st_s < 0) st_s = '0;
    if (st_s > 19'sd65535) st_s = 19'sd65535;
    gain_s = 18'sd16384 + 18'(goff_q);
    if (gain_s < 0) gain_s = '0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ggm_pkg::ST_IDLE:  if (accept && ggm_pkg::kind_e'(kind_i) == ggm_pkg::KIND_TICK)
                           state_d = ggm_pkg::ST_SPAWN;
      ggm_pkg::ST_SPAWN: state_d = ggm_pkg::ST_READ;
      ggm_pkg::ST_READ:  state_d = ggm_pkg::ST_ADDR;
      ggm_pkg::ST_ADDR:  state_d = ggm_pkg::ST_WAIT;
      ggm_pkg::ST_WAIT:  state_d = phase_q ? ggm_pkg::ST_MUL : ggm_pkg::ST_WAIT;
      ggm_pkg::ST_MUL:   state_d = ggm_pkg::ST_ACC;
      ggm_pkg::ST_ACC:   state_d = (slot_q == SW'(GRAIN_SLOTS - 1)) ?
                                   ggm_pkg::ST_OUT : ggm_pkg::ST_READ;
      ggm_pkg::ST_OUT:   state_d = ggm_pkg::ST_IDLE;
      default:           state_d = ggm_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses.
  always_ff @(posedge clk_i) begin
    if (accept && ggm_pkg::kind_e'(kind_i) == ggm_pkg::KIND_SRC &&
        {1'b0, address_i} < 17'(SOURCE_DEPTH))
      src_mem[AW'(address_i)] <= load_value_i;
    if (accept && ggm_pkg::kind_e'(kind_i) == ggm_pkg::KIND_WIN &&
        {1'b0, address_i} < 17'(WINDOW_DEPTH))
      win_mem[WW'(address_i)] <= load_value_i;
  end

  logic [32:0] rd_pos;
  logic [20:0] rd_idx;
  assign rd_pos = pos_q;
  assign rd_idx = rd_pos[32:12] + {20'd0, phase_q};

  // The sample at idx arrives in the second wait cycle, the one at idx+1 in
  // the multiply cycle.
  logic signed [15:0] src_rd_q, win_rd_q;
  always_ff @(posedge clk_i) begin
    src_rd_q <= src_mem[AW'(rd_idx)];
    win_rd_q <= win_mem[WW'(g_age)];
  end

  logic [48:0] wb_rec;
  logic        wb_en;
  logic [15:0] age_inc;
  logic        retire;
  assign age_inc = (g_age != 16'hFFFF) ? g_age + 16'd1 : g_age;
  assign retire  = g_act && (age_inc >= grain_len_q);
  always_comb begin
    wb_en  = 1'b0;
    wb_rec = {~retire, g_start, age_inc, g_gain};
    if (state_q == ggm_pkg::ST_SPAWN && do_spawn) begin
      wb_en  = 1'b1;
      wb_rec = {1'b1, st_s[15:0], 16'd0, gain_s[15:0]};
    end else if (state_q == ggm_pkg::ST_ACC && g_act) begin
      wb_en = 1'b1;
    end
  end

  // The spawn step needs the old record of the target slot; it is fetched
  // in the idle cycle that accepts the tick.
  always_ff @(posedge clk_i) begin
    if (state_q == ggm_pkg::ST_IDLE)
      rec_rd_q <= grain_mem[next_q];
    else if (state_q == ggm_pkg::ST_READ)
      rec_rd_q <= grain_mem[slot_q];
    if (wb_en)
      grain_mem[(state_q == ggm_pkg::ST_SPAWN) ? next_q : slot_q] <= wb_rec;
  end

  // Datapath.
  logic [11:0] frac;
  logic signed [31:0] lerp_p;
  logic signed [16:0] lerp_v;
  logic [20:0] end_idx;
  assign frac    = pos_q[11:0];
  assign lerp_p  = (17'(src_rd_q) - 17'(s1_q)) * $signed({1'b0, frac});
  assign lerp_v  = 17'(s1_q) + 17'(lerp_p >>> 12);
  assign end_idx = pos_q[32:12] + 21'd1;

  // Window weight, full scale beyond the table, and the grain term.
  logic signed [17:0] wsel;
  logic signed [49:0] term;
  assign wsel = ({16'd0, g_age} < 32'(WINDOW_DEPTH)) ? 18'(win_rd_q) : 18'sd32768;
  assign term = lerp_q * wg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ggm_pkg::ST_IDLE;
      slot_q      <= '0;
      cnt_q       <= '0;
      next_q      <= '0;
      act_q       <= '0;
      spawned_q   <= 1'b0;
      slot_init_q <= '0;
      out_valid_o <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && !out_stall_i && state_q != ggm_pkg::ST_OUT) out_valid_o <= 1'b0;
      unique case (state_q)
        ggm_pkg::ST_SPAWN: begin
          slot_q <= '0;
          if (do_spawn) begin
            cnt_q     <= cnt_inc - spawn_int_q;
            spawned_q <= 1'b1;
            slot_init_q[next_q] <= 1'b1;
            if (!(slot_init_q[next_q] && rec_rd_q[48])) act_q <= act_q + CW'(1);
            next_q <= (next_q == SW'(GRAIN_SLOTS - 1)) ? '0 : next_q + SW'(1);
          end else begin
            cnt_q     <= cnt_inc;
            spawned_q <= 1'b0;
          end
        end
        ggm_pkg::ST_ADDR: phase_q <= 1'b0;
        ggm_pkg::ST_WAIT: phase_q <= 1'b1;
        ggm_pkg::ST_ACC: begin
          if (retire && act_q != '0) act_q <= act_q - CW'(1);
          slot_q <= slot_q + SW'(1);
        end
        ggm_pkg::ST_OUT: out_valid_o <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      jit_q  <= position_jitter_i;
      goff_q <= gain_offset_i;
    end
    if (state_q == ggm_pkg::ST_SPAWN) sum_q <= '0;
    if (state_q == ggm_pkg::ST_READ) begin
      pos_q <= 33'd0;
    end
    if (state_q == ggm_pkg::ST_ADDR) begin
      pos_q  <= {g_start, 12'd0} + 33'(g_age) * 33'(pitch_q);
    end
    if (state_q == ggm_pkg::ST_WAIT) begin
      if (phase_q) s1_q <= src_rd_q;
      wg_q <= wsel * $signed({1'b0, g_gain});
    end
    if (state_q == ggm_pkg::ST_MUL) begin
      play_q <= g_act && (g_age < grain_len_q) && ({12'd0, end_idx} < {16'd0, src_len_q});
      lerp_q <= lerp_v;
    end
    if (state_q == ggm_pkg::ST_ACC && play_q) sum_q <= sum_q + 52'(term);
    if (state_q == ggm_pkg::ST_OUT) begin
      mixed_sample_o  <= ((sum_q >>> 29) > 52'sd32767) ? 16'sd32767 :
                         ((sum_q >>> 29) < -52'sd32768) ? -16'sd32768 :
                         16'(sum_q >>> 29);
      active_grains_o <= 5'(act_q);
      spawned_o       <= spawned_q;
    end
  end

endmodule

>>> rtl/ggm_checker.sv
// ----------------------------------------------------------------------------
// ggm_checker
// Port-level checks of the granular grain mixer.
// ----------------------------------------------------------------------------
module ggm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  active_grains_o,
  input logic        spawned_o
);

  // A waiting result holds while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(active_grains_o) &&
    $stable(spawned_o))
    else $error("result changed while stalled");

  // Active count never exceeds the slot count.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> active_grains_o <= 5'(ggm_pkg::GrainSlots))
    else $error("active count out of range");

  // No input is taken while a result is blocked.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result blocked");

endmodule

bind granular_grain_mixer_core ggm_checker u_ggm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .active_grains_o(active_grains_o), .spawned_o(spawned_o)
);
